// ===== hdl/wpd_pkg.sv =====
// Shared types, codes and small helpers of the WAV PCM stream decoder.
package wpd_pkg;

  // Input kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_NEW   = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_HEADER  = 2'd0;
  localparam logic [1:0] RK_SAMPLE  = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;
  localparam logic [1:0] RK_DONE    = 2'd3;

  // Status codes, header checks in file order
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_BAD_RIFF      = 4'd1;
  localparam logic [3:0] ST_BAD_WAVE      = 4'd2;
  localparam logic [3:0] ST_BAD_FMT_TAG   = 4'd3;
  localparam logic [3:0] ST_BAD_FMT_SIZE  = 4'd4;
  localparam logic [3:0] ST_NOT_PCM       = 4'd5;
  localparam logic [3:0] ST_ZERO_CHANNELS = 4'd6;
  localparam logic [3:0] ST_ZERO_RATE     = 4'd7;
  localparam logic [3:0] ST_BAD_BITS      = 4'd8;
  localparam logic [3:0] ST_BAD_DATA_TAG  = 4'd9;
  localparam logic [3:0] ST_ZERO_SIZE     = 4'd10;
  localparam logic [3:0] ST_SIZE_ALIGN    = 4'd11;
  localparam logic [3:0] ST_TRUNCATED     = 4'd12;

  // Result queue depth; input is held off unless two slots are free
  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [3:0]         status;
    logic signed [31:0] sample_value;
    logic [15:0]        channels;
    logic [31:0]        sample_rate;
    logic [5:0]         bits_per_sample;
    logic [31:0]        frame_count;
    logic               last_of_run;
  } result_t;

  // Up to two results produced by one input transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Residue of a byte modulo 3 (4 == 1 mod 3, so add base-4 digits)
  function automatic logic [1:0] mod3_byte(input logic [7:0] d);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, d[1:0]} + {2'b00, d[3:2]} + {2'b00, d[5:4]} + {2'b00, d[7:6]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // Sum of two residues modulo 3
  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

endpackage

// ===== hdl/wav_pcm_stream_decoder.sv =====
// Top level of the WAV PCM stream decoder: byte channel in, result channel out.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+--------------------------------------
//  byte    | byte_valid / byte_stall     | kind, data_byte
//  result  | result_valid / result_stall | result_kind, status, sample_value,
//          |                             | channels, sample_rate, bits_per_sample,
//          |                             | frame_count, last_of_run
//
// One byte transaction per cycle while byte_stall is low; results are registered.
// The decoder state is registered; a 4-entry result queue holds results.
// The last data byte yields two results, so a stalled result side fills the queue
// and byte_stall rises while fewer than two queue entries are free.
// Synchronous reset clears the decoder state and empties the queue; no clearing pass.
module wav_pcm_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         data_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         result_kind,
  output logic [3:0]         status,
  output logic signed [31:0] sample_value,
  output logic [15:0]        channels,
  output logic [31:0]        sample_rate,
  output logic [5:0]         bits_per_sample,
  output logic [31:0]        frame_count,
  output logic               last_of_run
);
  import wpd_pkg::*;

  logic    take;
  logic    pop;
  push_t   push;
  result_t head;

  assign take = byte_valid & ~byte_stall;
  assign pop  = result_valid & ~result_stall;

  wpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .kind      (kind),
    .data_byte (data_byte),
    .push      (push)
  );

  wpd_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (pop),
    .head        (head),
    .not_empty   (result_valid),
    .nearly_full (byte_stall)
  );

  // Result fields from the queue head
  assign result_kind     = head.result_kind;
  assign status          = head.status;
  assign sample_value    = head.sample_value;
  assign channels        = head.channels;
  assign sample_rate     = head.sample_rate;
  assign bits_per_sample = head.bits_per_sample;
  assign frame_count     = head.frame_count;
  assign last_of_run     = head.last_of_run;

endmodule

// ===== hdl/wpd_core.sv =====
// Header checker, sample assembler and decoder state for one input transaction.
module wpd_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [1:0]     kind,
  input  logic [7:0]     data_byte,
  output wpd_pkg::push_t push
);
  import wpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_FAILED = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Byte index at which each header field is complete (IDX_SIZE_FIRST: first size byte)
  localparam logic [5:0] IDX_RIFF       = 6'd3;
  localparam logic [5:0] IDX_WAVE       = 6'd11;
  localparam logic [5:0] IDX_FMT_TAG    = 6'd15;
  localparam logic [5:0] IDX_FMT_SIZE   = 6'd19;
  localparam logic [5:0] IDX_FORMAT     = 6'd21;
  localparam logic [5:0] IDX_CHANNELS   = 6'd23;
  localparam logic [5:0] IDX_RATE       = 6'd27;
  localparam logic [5:0] IDX_BITS       = 6'd35;
  localparam logic [5:0] IDX_DATA_TAG   = 6'd39;
  localparam logic [5:0] IDX_SIZE_FIRST = 6'd40;
  localparam logic [5:0] IDX_DATA_SIZE  = 6'd43;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666d7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  phase_t      phase, phase_next;
  logic [5:0]  header_index, header_index_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [1:0]  size_mod3, size_mod3_next;
  logic [15:0] channel_total, channel_total_next;
  logic [31:0] rate_held, rate_held_next;
  logic [5:0]  bits_held, bits_held_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [23:0] sample_assembly, sample_assembly_next;
  logic [1:0]  sample_byte_count, sample_byte_count_next;
  logic [15:0] channel_position, channel_position_next;
  logic [31:0] frames_done, frames_done_next;

  logic [31:0] word;
  logic [31:0] word_le;
  logic [15:0] half_le;
  logic [1:0]  mod3_now;
  logic [3:0]  err;
  logic        accepted;
  logic        aligned;
  logic [2:0]  bytes_per;
  logic        complete;
  logic [31:0] q;
  logic [31:0] shifted;
  logic [15:0] cp_inc;
  logic [31:0] rem;
  result_t     r0, r1;
  logic [1:0]  n;

  // Shifted header word and its little-endian views
  assign word    = {word_assembly[23:0], data_byte};
  assign word_le = {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign half_le = {word[7:0], word[15:8]};
  assign mod3_now = mod3_add((header_index == IDX_SIZE_FIRST) ? 2'd0 : size_mod3,
                             mod3_byte(data_byte));

  // Data size divisible by the sample size (low byte of the size is word[31:24])
  always_comb begin
    case (bits_held)
      6'd16:   aligned = ~word[24];
      6'd24:   aligned = (mod3_now == 2'd0);
      6'd32:   aligned = (word[25:24] == 2'b00);
      default: aligned = 1'b1;
    endcase
  end

  // Header field checks
  always_comb begin
    err      = ST_OK;
    accepted = 1'b0;
    channel_total_next   = channel_total;
    rate_held_next       = rate_held;
    bits_held_next       = bits_held;
    bytes_remaining_next = bytes_remaining;
    unique case (header_index)
      IDX_RIFF:     if (word != TAG_RIFF) err = ST_BAD_RIFF;
      IDX_WAVE:     if (word != TAG_WAVE) err = ST_BAD_WAVE;
      IDX_FMT_TAG:  if (word != TAG_FMT) err = ST_BAD_FMT_TAG;
      IDX_FMT_SIZE: if (word_le != 32'd16) err = ST_BAD_FMT_SIZE;
      IDX_FORMAT:   if (half_le != 16'd1) err = ST_NOT_PCM;
      IDX_CHANNELS: begin
        if (half_le == 16'd0) err = ST_ZERO_CHANNELS;
        else channel_total_next = half_le;
      end
      IDX_RATE: begin
        if (word_le == 32'd0) err = ST_ZERO_RATE;
        else rate_held_next = word_le;
      end
      IDX_BITS: begin
        if (half_le != 16'd8 && half_le != 16'd16 && half_le != 16'd24 &&
            half_le != 16'd32) err = ST_BAD_BITS;
        else bits_held_next = half_le[5:0];
      end
      IDX_DATA_TAG: if (word != TAG_DATA) err = ST_BAD_DATA_TAG;
      IDX_DATA_SIZE: begin
        if (word_le == 32'd0) err = ST_ZERO_SIZE;
        else if (!aligned) err = ST_SIZE_ALIGN;
        else begin
          bytes_remaining_next = word_le;
          accepted = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sample assembly and Q1.31 normalization
  always_comb begin
    bytes_per = bits_held[5:3];
    if (bytes_per == 3'd0 || bytes_per > 3'd4) bytes_per = 3'd1;
    complete = ({1'b0, sample_byte_count} + 3'd1) >= bytes_per;
    case (bytes_per)
      3'd1:    q = {data_byte ^ 8'h80, 24'd0};
      3'd2:    q = {data_byte, sample_assembly[7:0], 16'd0};
      3'd3:    q = {data_byte, sample_assembly[15:0], 8'd0};
      default: q = {data_byte, sample_assembly};
    endcase
    shifted = {24'd0, data_byte} << {sample_byte_count, 3'b000};
    cp_inc  = channel_position + 16'd1;
    rem     = bytes_remaining - 32'd1;
  end

  // Next state and results of this transaction
  always_comb begin
    phase_next             = phase;
    header_index_next      = header_index;
    word_assembly_next     = word_assembly;
    size_mod3_next         = size_mod3;
    sample_assembly_next   = sample_assembly;
    sample_byte_count_next = sample_byte_count;
    channel_position_next  = channel_position;
    frames_done_next       = frames_done;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (take) begin
      if (kind == KIND_NEW) begin
        phase_next             = PH_HEADER;
        header_index_next      = '0;
        word_assembly_next     = '0;
        size_mod3_next         = '0;
        sample_assembly_next   = '0;
        sample_byte_count_next = '0;
        channel_position_next  = '0;
        frames_done_next       = '0;
      end else if ((kind == KIND_BYTE || kind == KIND_EOF) &&
                   (phase == PH_HEADER || phase == PH_DATA)) begin
        if (kind == KIND_EOF) begin
          r0.result_kind = RK_ERROR;
          r0.status      = ST_TRUNCATED;
          n = 2'd1;
          phase_next = PH_FAILED;
        end else if (phase == PH_HEADER) begin
          word_assembly_next = word;
          size_mod3_next     = mod3_now;
          if (err != ST_OK) begin
            r0.result_kind = RK_ERROR;
            r0.status      = err;
            n = 2'd1;
            phase_next = PH_FAILED;
          end else begin
            header_index_next = header_index + 6'd1;
            if (accepted) begin
              r0.result_kind     = RK_HEADER;
              r0.channels        = channel_total_next;
              r0.sample_rate     = rate_held_next;
              r0.bits_per_sample = bits_held_next;
              n = 2'd1;
              phase_next = PH_DATA;
            end
          end
        end else begin
          if (complete) begin
            r0.result_kind  = RK_SAMPLE;
            r0.sample_value = q;
            n = 2'd1;
            sample_assembly_next   = '0;
            sample_byte_count_next = '0;
            if (cp_inc >= channel_total) begin
              channel_position_next = '0;
              frames_done_next      = frames_done + 32'd1;
            end else begin
              channel_position_next = cp_inc;
            end
          end else begin
            sample_assembly_next   = sample_assembly | shifted[23:0];
            sample_byte_count_next = sample_byte_count + 2'd1;
          end
          if (rem == 32'd0) begin
            if (complete) begin
              r1.result_kind = RK_DONE;
              r1.frame_count = frames_done_next;
              n = 2'd2;
            end else begin
              r0.result_kind = RK_DONE;
              r0.frame_count = frames_done_next;
              n = 2'd1;
            end
            phase_next = PH_DONE;
          end
        end
      end
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign push = {n, r0, r1};

  // Decoder state; header fields clear on a new file and load only while the header is parsed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_index      <= '0;
      word_assembly     <= '0;
      size_mod3         <= '0;
      channel_total     <= '0;
      rate_held         <= '0;
      bits_held         <= '0;
      bytes_remaining   <= '0;
      sample_assembly   <= '0;
      sample_byte_count <= '0;
      channel_position  <= '0;
      frames_done       <= '0;
    end else begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      word_assembly     <= word_assembly_next;
      size_mod3         <= size_mod3_next;
      sample_assembly   <= sample_assembly_next;
      sample_byte_count <= sample_byte_count_next;
      channel_position  <= channel_position_next;
      frames_done       <= frames_done_next;
      if (take && kind == KIND_NEW) begin
        channel_total   <= '0;
        rate_held       <= '0;
        bits_held       <= '0;
        bytes_remaining <= '0;
      end else if (take && kind == KIND_BYTE && phase == PH_HEADER && err == ST_OK) begin
        channel_total   <= channel_total_next;
        rate_held       <= rate_held_next;
        bits_held       <= bits_held_next;
        bytes_remaining <= bytes_remaining_next;
      end else if (take && kind == KIND_BYTE && phase == PH_DATA) begin
        bytes_remaining <= rem;
      end
    end
  end

  // Two results only come from the last data byte
  assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (phase == PH_DATA && push.second.result_kind == RK_DONE))
    else $error("second result without end of data");

  // Samples are only produced once the header is accepted
  assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0 && push.first.result_kind == RK_SAMPLE) |-> (phase == PH_DATA))
    else $error("sample outside data phase");

  // Done and failed are absorbing until a new file starts
  assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_DONE || phase == PH_FAILED) && !(take && kind == KIND_NEW))
    |=> $stable(phase))
    else $error("left terminal phase without restart");

endmodule

// ===== hdl/wpd_result_fifo.sv =====
// Small result queue between the decoder and the result channel.
module wpd_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  wpd_pkg::push_t   push,
  input  logic             pop,
  output wpd_pkg::result_t head,
  output logic             not_empty,
  output logic             nearly_full
);
  import wpd_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign head        = entries[rd_ptr];
  assign not_empty   = (count != '0);
  assign nearly_full = (count > CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  // Entry storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + PTR_W'(1)] <= push.second;
  end

  assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(push.count) + count) <= CNT_W'(FIFO_DEPTH) || pop)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

  assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> (count == $past(count) - CNT_W'(1)))
    else $error("fill count did not drop on pop");

endmodule

// ===== bench/wpd_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the WAV PCM stream decoder: mirrors the decoder and compares every result.
module wpd_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         result_kind,
  input  logic [3:0]         status,
  input  logic signed [31:0] sample_value,
  input  logic [15:0]        channels,
  input  logic [31:0]        sample_rate,
  input  logic [5:0]         bits_per_sample,
  input  logic [31:0]        frame_count,
  input  logic               last_of_run,
  output int                 mismatches,
  output int                 pending
);
  import wpd_pkg::*;

  // Offset of the last byte of each checked header field
  localparam logic [5:0] OFS_RIFF_TAG  = 6'd3;
  localparam logic [5:0] OFS_WAVE_TAG  = 6'd11;
  localparam logic [5:0] OFS_FMT_TAG   = 6'd15;
  localparam logic [5:0] OFS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] OFS_FORMAT    = 6'd21;
  localparam logic [5:0] OFS_CHANNELS  = 6'd23;
  localparam logic [5:0] OFS_RATE      = 6'd27;
  localparam logic [5:0] OFS_BITS      = 6'd35;
  localparam logic [5:0] OFS_DATA_TAG  = 6'd39;
  localparam logic [5:0] OFS_DATA_SIZE = 6'd43;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;
  localparam int          REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {P_HEADER, P_DATA, P_FAILED, P_DONE} dec_phase_t;

  // Mirrored decoder state
  dec_phase_t  ph;
  logic [5:0]  hdr_pos;
  logic [31:0] hdr_word;
  logic [15:0] chan_total;
  logic [31:0] rate_seen;
  logic [5:0]  bits_seen;
  logic [31:0] bytes_left;
  logic [23:0] partial;
  logic [1:0]  partial_cnt;
  logic [15:0] chan_pos;
  logic [31:0] frames;

  result_t decoded_q[$];

  function automatic void clear_decoder();
    ph          = P_HEADER;
    hdr_pos     = '0;
    hdr_word    = '0;
    chan_total  = '0;
    rate_seen   = '0;
    bits_seen   = '0;
    bytes_left  = '0;
    partial     = '0;
    partial_cnt = '0;
    chan_pos    = '0;
    frames      = '0;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf(
      "kind=%0d status=%0d sample=%h ch=%0d rate=%0d bits=%0d frames=%0d last=%0b",
      r.result_kind, r.status, r.sample_value, r.channels, r.sample_rate,
      r.bits_per_sample, r.frame_count, r.last_of_run);
  endfunction

  // Work out the results that one byte transaction causes and queue them
  task automatic decode_byte(input logic [1:0] k, input logic [7:0] b);
    result_t     made [2];
    result_t     r;
    int          n;
    int          nb;
    int          i;
    logic [3:0]  err;
    logic [15:0] h16;
    logic [31:0] h32;
    logic [31:0] raw;
    logic [31:0] q;
    bit          taken;
    n = 0;
    taken = 1'b0;
    if (k == KIND_NEW) begin
      clear_decoder();
    end else if ((k == KIND_BYTE || k == KIND_EOF) && (ph == P_HEADER || ph == P_DATA)) begin
      if (k == KIND_EOF) begin
        r = '0;
        r.result_kind = RK_ERROR;
        r.status = ST_TRUNCATED;
        made[n] = r;
        n++;
        ph = P_FAILED;
      end else if (ph == P_HEADER) begin
        // header: shift in the byte, check a field once its last byte is in
        hdr_word = {hdr_word[23:0], b};
        h32 = {hdr_word[7:0], hdr_word[15:8], hdr_word[23:16], hdr_word[31:24]};
        h16 = {hdr_word[7:0], hdr_word[15:8]};
        err = ST_OK;
        case (hdr_pos)
          OFS_RIFF_TAG: if (hdr_word != TAG_RIFF) err = ST_BAD_RIFF;
          OFS_WAVE_TAG: if (hdr_word != TAG_WAVE) err = ST_BAD_WAVE;
          OFS_FMT_TAG:  if (hdr_word != TAG_FMT) err = ST_BAD_FMT_TAG;
          OFS_FMT_SIZE: if (h32 != FMT_CHUNK_SIZE) err = ST_BAD_FMT_SIZE;
          OFS_FORMAT:   if (h16 != FORMAT_PCM) err = ST_NOT_PCM;
          OFS_CHANNELS: begin
            if (h16 == 16'd0) err = ST_ZERO_CHANNELS;
            else chan_total = h16;
          end
          OFS_RATE: begin
            if (h32 == 32'd0) err = ST_ZERO_RATE;
            else rate_seen = h32;
          end
          OFS_BITS: begin
            if (h16 != 16'd8 && h16 != 16'd16 && h16 != 16'd24 && h16 != 16'd32)
              err = ST_BAD_BITS;
            else
              bits_seen = h16[5:0];
          end
          OFS_DATA_TAG: if (hdr_word != TAG_DATA) err = ST_BAD_DATA_TAG;
          OFS_DATA_SIZE: begin
            if (h32 == 32'd0) err = ST_ZERO_SIZE;
            else if (h32 % {29'd0, bits_seen[5:3]} != 32'd0) err = ST_SIZE_ALIGN;
            else begin
              bytes_left = h32;
              taken = 1'b1;
            end
          end
          default: ;
        endcase
        if (err != ST_OK) begin
          r = '0;
          r.result_kind = RK_ERROR;
          r.status = err;
          made[n] = r;
          n++;
          ph = P_FAILED;
        end else begin
          hdr_pos = hdr_pos + 6'd1;
          if (taken) begin
            r = '0;
            r.result_kind = RK_HEADER;
            r.channels = chan_total;
            r.sample_rate = rate_seen;
            r.bits_per_sample = bits_seen;
            made[n] = r;
            n++;
            ph = P_DATA;
          end
        end
      end else begin
        // data: little-endian sample assembly, then scale to Q1.31
        nb = int'(bits_seen[5:3]);
        if (nb == 0 || nb > 4) nb = 1;
        if (int'(partial_cnt) + 1 >= nb) begin
          raw = {8'h00, partial} | ({24'h0, b} << (8 * (nb - 1)));
          case (nb)
            1:       q = {raw[7:0] ^ 8'h80, 24'h0};
            2:       q = {raw[15:0], 16'h0};
            3:       q = {raw[23:0], 8'h0};
            default: q = raw;
          endcase
          r = '0;
          r.result_kind = RK_SAMPLE;
          r.sample_value = q;
          made[n] = r;
          n++;
          partial = '0;
          partial_cnt = '0;
          chan_pos = chan_pos + 16'd1;
          if (chan_pos >= chan_total) begin
            chan_pos = '0;
            frames = frames + 32'd1;
          end
        end else begin
          partial = partial | ({16'h0, b} << (8 * partial_cnt));
          partial_cnt = partial_cnt + 2'd1;
        end
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          r = '0;
          r.result_kind = RK_DONE;
          r.frame_count = frames;
          made[n] = r;
          n++;
          ph = P_DONE;
        end
      end
    end
    if (n > 0) made[n - 1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) decoded_q.push_back(made[i]);
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    result_t got;
    result_t want;
    got.result_kind     = result_kind;
    got.status          = status;
    got.sample_value    = sample_value;
    got.channels        = channels;
    got.sample_rate     = sample_rate;
    got.bits_per_sample = bits_per_sample;
    got.frame_count     = frame_count;
    got.last_of_run     = last_of_run;
    if (decoded_q.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result with none expected: %s", $time, show(got));
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      if (got !== want) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      // predict first so a same-edge result never sees a stale queue
      if (byte_valid && !byte_stall) decode_byte(kind, data_byte);
      if (result_valid && !result_stall) check_result();
    end
    pending <= decoded_q.size();
  end

endmodule

// ===== bench/tb_wav_pcm_stream_decoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the WAV PCM stream decoder: file stimulus, flow control and verdict.
module tb_wav_pcm_stream_decoder;
  import wpd_pkg::*;

  localparam logic [1:0] KIND_IGNORED  = 2'd3;
  localparam int         ITEM_TARGET   = 1050;
  localparam int         HOLD_CYCLES   = 150;
  localparam int         SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               byte_valid = 1'b0;
  logic               byte_stall;
  logic [1:0]         kind = KIND_BYTE;
  logic [7:0]         data_byte = 8'h00;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         result_kind;
  logic [3:0]         status;
  logic signed [31:0] sample_value;
  logic [15:0]        channels;
  logic [31:0]        sample_rate;
  logic [5:0]         bits_per_sample;
  logic [31:0]        frame_count;
  logic               last_of_run;

  int mismatches;
  int pending;

  int send_pct = 28;
  int recv_pct = 88;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  logic [7:0] file_bytes[$];

  always #1 clk = ~clk;

  wav_pcm_stream_decoder dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .kind(kind), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_kind(result_kind), .status(status), .sample_value(sample_value),
    .channels(channels), .sample_rate(sample_rate), .bits_per_sample(bits_per_sample),
    .frame_count(frame_count), .last_of_run(last_of_run)
  );

  wpd_result_checker chk (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .kind(kind), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_kind(result_kind), .status(status), .sample_value(sample_value),
    .channels(channels), .sample_rate(sample_rate), .bits_per_sample(bits_per_sample),
    .frame_count(frame_count), .last_of_run(last_of_run),
    .mismatches(mismatches), .pending(pending)
  );

  // Result side: random stalls, plus one long hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // One byte-side transaction, with random idle cycles in front
  task automatic send(input logic [1:0] k, input logic [7:0] d, input bit counted);
    while ($urandom_range(99) < send_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    kind <= k;
    data_byte <= d;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void put_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_tag(input logic [31:0] t);
    put_le({t[7:0], t[15:8], t[23:16], t[31:24]}, 4);
  endfunction

  // Short hand-picked sequence: tag failure, early EOF, ignored kinds, restarts
  task automatic directed_run();
    send(KIND_NEW, 8'h00, 1'b1);
    send(KIND_BYTE, "R", 1'b1);
    send(KIND_BYTE, "I", 1'b1);
    send(KIND_BYTE, "F", 1'b1);
    send(KIND_BYTE, "X", 1'b1);
    send(KIND_BYTE, 8'hFF, 1'b1);
    send(KIND_EOF, 8'h00, 1'b1);
    send(KIND_NEW, 8'hFF, 1'b1);
    send(KIND_EOF, 8'hFF, 1'b1);
    send(KIND_NEW, 8'h5A, 1'b1);
    send(KIND_BYTE, "R", 1'b1);
    send(KIND_BYTE, "I", 1'b1);
    send(KIND_IGNORED, 8'hFF, 1'b1);
    send(KIND_BYTE, "F", 1'b1);
    send(KIND_BYTE, "F", 1'b1);
    send(KIND_BYTE, 8'h00, 1'b1);
    send(KIND_BYTE, 8'hFF, 1'b1);
    send(KIND_EOF, 8'h00, 1'b1);
    send(KIND_NEW, 8'h00, 1'b1);
    send(KIND_BYTE, "R", 1'b1);
    send(KIND_IGNORED, 8'h00, 1'b1);
    send(KIND_NEW, 8'h00, 1'b1);
  endtask

  // One random file: mostly well-formed, sometimes flawed, cut short or padded
  task automatic send_file();
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] size;
    logic [31:0] size_field;
    int          nb;
    int          nsamp;
    int          stop_at;
    int          roll;
    int          i;
    bit          flawed;
    bit          endless;
    bit          cut_eof;
    bit          cut_new;
    flawed = 1'b0;
    endless = 1'b0;

    roll = $urandom_range(99);
    if (roll < 90) begin
      case ($urandom_range(3))
        0: bits = 16'd8;
        1: bits = 16'd16;
        2: bits = 16'd24;
        default: bits = 16'd32;
      endcase
      nb = int'(bits) / 8;
    end else begin
      bits = 16'($urandom_range(16'hFFFF));
      nb = 1;
      flawed = 1'b1;
    end

    roll = $urandom_range(99);
    if (roll < 5) begin
      chans = 16'd0;
      flawed = 1'b1;
    end else if (roll < 10) chans = 16'hFFFF;
    else chans = 16'($urandom_range(4, 1));

    roll = $urandom_range(99);
    if (roll < 5) begin
      rate = 32'd0;
      flawed = 1'b1;
    end else if (roll < 10) rate = 32'hFFFF_FFFF;
    else rate = $urandom;

    nsamp = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13);
    size = nb * nsamp;
    size_field = size;
    roll = $urandom_range(99);
    if (roll < 5) begin
      size_field = 32'd0;
      flawed = 1'b1;
    end else if (roll < 10 && nb > 1) begin
      size_field = size + $urandom_range(nb - 1, 1);
      flawed = 1'b1;
    end else if (roll < 14 && nb == 1) begin
      // claims far more data than arrives, so the file ends truncated
      size_field = 32'hFFFF_FFFF;
      endless = 1'b1;
    end

    file_bytes.delete();
    put_tag("RIFF");
    put_le(size_field + 32'd36, 4);
    put_tag("WAVE");
    put_tag("fmt ");
    put_le(32'd16, 4);
    put_le(32'd1, 2);
    put_le({16'd0, chans}, 2);
    put_le(rate, 4);
    put_le(rate * nb * chans, 4);
    put_le(nb * chans, 2);
    put_le({16'd0, bits}, 2);
    put_tag("data");
    put_le(size_field, 4);

    if ($urandom_range(99) < 12) begin
      i = $urandom_range(43);
      file_bytes[i] = file_bytes[i] ^ 8'($urandom_range(255, 1));
      flawed = 1'b1;
    end
    if (!flawed) begin
      for (i = 0; i < size; i++) file_bytes.push_back(8'($urandom_range(255)));
    end

    roll = $urandom_range(99);
    cut_eof = (roll < 7) || endless;
    cut_new = (roll >= 7 && roll < 11) && !endless;
    stop_at = file_bytes.size();
    if ((cut_eof || cut_new) && !endless) stop_at = $urandom_range(file_bytes.size() - 1);

    send(KIND_NEW, 8'($urandom_range(255)), 1'b1);
    for (i = 0; i < stop_at; i++) begin
      if ($urandom_range(99) < 3) send(KIND_IGNORED, 8'($urandom_range(255)), 1'b0);
      send(KIND_BYTE, file_bytes[i], 1'b1);
    end
    if (cut_eof) begin
      send(KIND_EOF, 8'($urandom_range(255)), 1'b1);
    end else if (!cut_new && !flawed && $urandom_range(99) < 10) begin
      // trailing bytes after the data chunk are ignored
      repeat ($urandom_range(3, 1)) send(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
      send(KIND_EOF, 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int mode;
    mode = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_run();
    while (items_sent < ITEM_TARGET) begin
      if (mode == 0 && items_sent >= ITEM_TARGET / 3) begin
        drain();
        send_pct = 88;
        recv_pct <= 28;
        mode = 1;
      end else if (mode == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        drain();
        send_pct = 0;
        recv_pct <= 0;
        hold_go <= 1'b1;
        mode = 2;
      end
      send_file();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
